### hdl/periodic_query_scheduler_top_macros.svh
// Assertion macros for the periodic query scheduler.
`ifndef PERIODIC_QUERY_SCHEDULER_TOP_MACROS_SVH
`define PERIODIC_QUERY_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define PQS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PQS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/psq_pkg.sv
// Package for the periodic query scheduler: sizes, codes, entry and control structs.
package psq_pkg;

	localparam int MAX_QUERIES = 64;
	localparam int ADDR_W      = $clog2(MAX_QUERIES);
	localparam int CNT_W       = $clog2(MAX_QUERIES + 1);
	localparam int CHW         = ADDR_W + 2;

	typedef enum logic {
		OP_REG  = 1'b0,
		OP_NEXT = 1'b1
	} psq_op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_LIMIT = 2'd3
	} psq_status_t;

	// field order makes a plain compare equal to due, then id, then period
	typedef struct packed {
		logic [31:0] due;
		logic [15:0] id;
		logic [11:0] period;
	} psq_entry_t;

	localparam int ENTRY_W = $bits(psq_entry_t);

	typedef struct packed {
		logic        start;
		psq_op_t     opcode;
		logic [15:0] qid;
		logic [11:0] period;
		logic        grant_ok;
	} psq_cmd_t;

	typedef struct packed {
		logic        idle;
		logic        done;
		logic        granted;
		psq_status_t status;
		logic [15:0] id;
		logic [31:0] due;
		logic [CNT_W-1:0] count;
	} psq_res_t;

endpackage

### hdl/periodic_query_scheduler_top.sv
// Top level of the periodic query scheduler: stream ports, grant limit, output register.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | tdata {query_id, period}, tuser {opcode}
//  m_      | out | m_tvalid/m_tready  | tdata {result_id, due_time}, tuser {status}
//  cfg_    | in  | cfg_we             | cfg_wdata = grant_limit
//
// Register: sift-up, a parent read then a compare per level; next: root read, advance,
// then sift-down, a left read, a right read and a compare per level; full, empty and
// limit answers go straight to done. The heap RAM's single read port sets these steps.
// One item in flight; a finished result waits in the output register while the
// next item is taken. No clearing pass after reset.
`include "periodic_query_scheduler_top_macros.svh"
module periodic_query_scheduler_top import psq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] query_id, [27:16] period, [31:28] zero
	input  logic [0:0]  s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [15:0] result_id, [47:16] due_time
	output logic [1:0]  m_tuser,   // [1:0] status
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic [15:0] limit_q;
	logic [15:0] grants_q;
	logic        m_valid_q;
	logic [47:0] m_data_q;
	logic [1:0]  m_user_q;
	logic        slot_free;
	psq_cmd_t    cmd;
	psq_res_t    res;

	assign slot_free = !m_valid_q || m_tready;
	assign s_tready  = res.idle;

	assign cmd.start    = s_tvalid && s_tready;
	assign cmd.opcode   = psq_op_t'(s_tuser[0]);
	assign cmd.qid      = s_tdata[15:0];
	assign cmd.period   = s_tdata[27:16];
	assign cmd.grant_ok = (grants_q < limit_q);

	psq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.take   (slot_free),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= 16'hFFFF;
			grants_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (res.done) begin
				m_valid_q <= 1'b1;
				if (res.granted) begin
					grants_q <= grants_q + 16'd1;
				end
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			m_data_q <= {res.due, res.id};
			m_user_q <= res.status;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	`PQS_ASSERT_NOW(a_count_bound, 1'b1, res.count <= CNT_W'(MAX_QUERIES), "entry count past capacity")
	`PQS_ASSERT_NOW(a_no_overwrite, res.done, !m_valid_q || m_tready, "result overwritten before taken")
	`PQS_ASSERT_NEXT(a_grant_step, res.done && res.granted, grants_q == 16'($past(grants_q) + 16'd1), "grant count did not step")
	`PQS_ASSERT_NOW(a_busy_not_ready, !res.idle, !s_tready, "input taken while busy")

endmodule

### hdl/psq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/psq_alu.sv
// Shared unit: heap order compare and saturating due-time advance.
module psq_alu import psq_pkg::*; (
	input  psq_entry_t  a,
	input  psq_entry_t  b,
	output logic        lt,
	output logic [31:0] due_adv
);

	logic [32:0] sum;

	assign lt      = (a < b);
	assign sum     = {1'b0, a.due} + 33'(a.period);
	assign due_adv = sum[32] ? '1 : sum[31:0];

endmodule

### hdl/psq_core.sv
// Heap sequencer: insert with sift-up, pop-advance with sift-down, over one RAM.
module psq_core import psq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  psq_cmd_t cmd,
	input  logic     take,
	output psq_res_t res
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_UP_RD  = 9'b000000010,
		S_UP_CMP = 9'b000000100,
		S_NX_RD  = 9'b000001000,
		S_NX_ADV = 9'b000010000,
		S_DN_RDL = 9'b000100000,
		S_DN_RDR = 9'b001000000,
		S_DN_CMP = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	psq_entry_t       cur_q, cur_d, best_q, best_d;
	logic [ADDR_W-1:0] pos_q, pos_d, par_q, par_d, bidx_q, bidx_d;
	logic             bsel_q, bsel_d;
	psq_status_t      st_q, st_d;
	logic             gr_q, gr_d;
	logic [15:0]      rid_q, rid_d;
	logic [31:0]      rdue_q, rdue_d;

	logic              we;
	logic [ADDR_W-1:0] waddr, raddr;
	psq_entry_t        wdata, rdata;
	psq_entry_t        opa, opb;
	logic              lt;
	logic [31:0]       due_adv;
	logic [CHW-1:0]    lchild, rchild, cnt_x;
	logic              r_ok;

	psq_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_QUERIES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	psq_alu u_alu (
		.a       (opa),
		.b       (opb),
		.lt      (lt),
		.due_adv (due_adv)
	);

	assign lchild = CHW'({pos_q, 1'b1});
	assign rchild = lchild + CHW'(1);
	assign cnt_x  = CHW'(cnt_q);
	assign r_ok   = (rchild < cnt_x);

	always_comb begin
		opa = rdata;
		opb = best_q;
		if (state_q == S_UP_CMP) begin
			opa = cur_q;
			opb = rdata;
		end else if (state_q == S_DN_RDR) begin
			opb = cur_q;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cur_d   = cur_q;
		best_d  = best_q;
		pos_d   = pos_q;
		par_d   = par_q;
		bidx_d  = bidx_q;
		bsel_d  = bsel_q;
		st_d    = st_q;
		gr_d    = gr_q;
		rid_d   = rid_q;
		rdue_d  = rdue_q;
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = cur_q;
		raddr   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.start) begin
					gr_d   = 1'b0;
					st_d   = ST_OK;
					rdue_d = '0;
					if (cmd.opcode == OP_REG) begin
						rid_d = cmd.qid;
						if (cnt_q == CNT_W'(MAX_QUERIES)) begin
							st_d    = ST_FULL;
							state_d = S_DONE;
						end else begin
							cur_d   = '{due: 32'(cmd.period), id: cmd.qid, period: cmd.period};
							pos_d   = cnt_q[ADDR_W-1:0];
							cnt_d   = cnt_q + CNT_W'(1);
							state_d = S_UP_RD;
						end
					end else begin
						rid_d = '0;
						if (!cmd.grant_ok) begin
							st_d    = ST_LIMIT;
							state_d = S_DONE;
						end else if (cnt_q == '0) begin
							st_d    = ST_EMPTY;
							state_d = S_DONE;
						end else begin
							gr_d    = 1'b1;
							state_d = S_NX_RD;
						end
					end
				end
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					we      = 1'b1;
					state_d = S_DONE;
				end else begin
					par_d   = ADDR_W'((pos_q - ADDR_W'(1)) >> 1);
					raddr   = par_d;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				we = 1'b1;
				if (lt) begin
					wdata   = rdata;
					pos_d   = par_q;
					state_d = S_UP_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_NX_RD: begin
				raddr   = '0;
				state_d = S_NX_ADV;
			end
			S_NX_ADV: begin
				rid_d   = rdata.id;
				rdue_d  = rdata.due;
				cur_d   = '{due: due_adv, id: rdata.id, period: rdata.period};
				pos_d   = '0;
				state_d = S_DN_RDL;
			end
			S_DN_RDL: begin
				if (lchild >= cnt_x) begin
					we      = 1'b1;
					state_d = S_DONE;
				end else begin
					raddr   = lchild[ADDR_W-1:0];
					state_d = S_DN_RDR;
				end
			end
			S_DN_RDR: begin
				raddr = rchild[ADDR_W-1:0];
				if (lt) begin
					best_d = rdata;
					bidx_d = lchild[ADDR_W-1:0];
					bsel_d = 1'b1;
				end else begin
					best_d = cur_q;
					bsel_d = 1'b0;
				end
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				we = 1'b1;
				if (r_ok && lt) begin
					wdata   = rdata;
					pos_d   = rchild[ADDR_W-1:0];
					state_d = S_DN_RDL;
				end else if (bsel_q) begin
					wdata   = best_q;
					pos_d   = bidx_q;
					state_d = S_DN_RDL;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q  <= cur_d;
		best_q <= best_d;
		pos_q  <= pos_d;
		par_q  <= par_d;
		bidx_q <= bidx_d;
		bsel_q <= bsel_d;
		st_q   <= st_d;
		gr_q   <= gr_d;
		rid_q  <= rid_d;
		rdue_q <= rdue_d;
	end

	assign res.idle    = (state_q == S_IDLE);
	assign res.done    = (state_q == S_DONE) && take;
	assign res.granted = gr_q;
	assign res.status  = st_q;
	assign res.id      = rid_q;
	assign res.due     = rdue_q;
	assign res.count   = cnt_q;

endmodule
